// ===== rtl/sis_pkg.sv =====
// Shared types and constants for the sorted integer set.
// Used by every module of the block; depends on nothing else.
package sis_pkg;

   localparam int CAPACITY = 64;
   localparam int COUNT_W  = $clog2(CAPACITY + 1);
   localparam int VALUE_W  = 32;
   localparam int CMD_W    = 3;
   localparam int STATUS_W = 2;
   localparam int RANK_W   = 7;
   localparam int SIZE_W   = 7;

   // Popcount tree: groups of GROUP bits are summed in the first stage.
   localparam int GROUP    = 8;
   localparam int NGROUPS  = (CAPACITY + GROUP - 1) / GROUP;
   localparam int GSUM_W   = $clog2(GROUP + 1);

   localparam logic [CMD_W-1:0] CMD_INSERT = 3'd0;
   localparam logic [CMD_W-1:0] CMD_DELETE = 3'd1;
   localparam logic [CMD_W-1:0] CMD_MEMBER = 3'd2;
   localparam logic [CMD_W-1:0] CMD_GREATER = 3'd3;
   localparam logic [CMD_W-1:0] CMD_LESS   = 3'd4;

   localparam logic [STATUS_W-1:0] STATUS_OK   = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_MISS = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_FULL = 2'd2;

   typedef struct packed {
      logic [CMD_W-1:0]          command;
      logic signed [VALUE_W-1:0] value;
   } req_type;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [RANK_W-1:0]   rank_count;
      logic [SIZE_W-1:0]   set_size;
      logic                is_empty;
   } rsp_type;

   // Broadcast from the controller to every cell.
   typedef struct packed {
      logic                      capture;
      logic                      insert;
      logic                      delete_op;
      logic signed [VALUE_W-1:0] value;
   } cell_ctl_type;

endpackage

// ===== rtl/sis_cell.sv =====
// One storage cell of the sorted set chain: an element, its valid bit and compare flags.
// Depends on sis_pkg.
module sis_cell (
   input  logic                               clock,
   input  logic                               reset,
   input  sis_pkg::cell_ctl_type              ctl,
   input  logic signed [sis_pkg::VALUE_W-1:0] left_value,
   input  logic                               left_valid,
   input  logic                               left_lt,
   input  logic signed [sis_pkg::VALUE_W-1:0] right_value,
   input  logic                               right_valid,
   output logic signed [sis_pkg::VALUE_W-1:0] value,
   output logic                               valid,
   output logic                               lt,
   output logic                               eq,
   output logic                               gt
);
   import sis_pkg::*;

   logic signed [VALUE_W-1:0] value_ff, value_in;
   logic                      valid_ff, valid_in;
   logic                      lt_ff, lt_in;
   logic                      eq_ff, eq_in;
   logic                      gt_ff, gt_in;

   always_comb begin
      value_in = value_ff;
      valid_in = valid_ff;
      lt_in    = lt_ff;
      eq_in    = eq_ff;
      gt_in    = gt_ff;
      priority if (ctl.capture) begin
         lt_in = valid_ff && (value_ff < ctl.value);
         eq_in = valid_ff && (value_ff == ctl.value);
         gt_in = valid_ff && (value_ff > ctl.value);
      end else if (ctl.insert) begin
         // Cells at or above the insertion point move up by one; the first of
         // them takes the new value.
         if (!lt_ff) begin
            valid_in = valid_ff | left_valid;
            value_in = left_lt ? ctl.value : left_value;
         end
      end else if (ctl.delete_op) begin
         // The matching cell and everything above it move down by one.
         if (!lt_ff) begin
            valid_in = right_valid;
            value_in = right_value;
         end
      end else begin
         value_in = value_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
      lt_ff    <= lt_in;
      eq_ff    <= eq_in;
      gt_ff    <= gt_in;
   end

   assign value = value_ff;
   assign valid = valid_ff;
   assign lt    = lt_ff;
   assign eq    = eq_ff;
   assign gt    = gt_ff;

endmodule

// ===== rtl/sis_popcnt.sv =====
// Two-level population count over the cell flags: registered group sums, then a total.
// Depends on sis_pkg.
module sis_popcnt (
   input  logic                          clock,
   input  logic [sis_pkg::CAPACITY-1:0]  bits,
   output logic [sis_pkg::COUNT_W-1:0]   total
);
   import sis_pkg::*;

   logic [GSUM_W-1:0] group_ff [NGROUPS];
   logic [GSUM_W-1:0] group_in [NGROUPS];

   always_comb begin
      for (int g = 0; g < NGROUPS; g++) begin
         group_in[g] = '0;
         for (int b = 0; b < GROUP; b++) begin
            if (g * GROUP + b < CAPACITY) begin
               group_in[g] = group_in[g] + GSUM_W'(bits[g * GROUP + b]);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      group_ff <= group_in;
   end

   always_comb begin
      total = '0;
      for (int g = 0; g < NGROUPS; g++) begin
         total = total + COUNT_W'(group_ff[g]);
      end
   end

endmodule

// ===== rtl/sis_ctl.sv =====
// Sequencer of the sorted set: request capture, cell commands, element count and response.
// Depends on sis_pkg.
module sis_ctl (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  sis_pkg::req_type              req_payload,
   output logic                          rsp_strobe,
   output sis_pkg::rsp_type              rsp_payload,
   output sis_pkg::cell_ctl_type         cell_ctl,
   input  logic [sis_pkg::CAPACITY-1:0]  eq_flags,
   input  logic [sis_pkg::CAPACITY-1:0]  lt_flags,
   input  logic [sis_pkg::CAPACITY-1:0]  gt_flags,
   output logic [sis_pkg::CAPACITY-1:0]  count_bits,
   input  logic [sis_pkg::COUNT_W-1:0]   count_total
);
   import sis_pkg::*;

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_APPLY = 2'd1;
   localparam logic [1:0] ST_SUM   = 2'd2;

   logic [1:0]                state_ff, state_in;
   logic [CMD_W-1:0]          cmd_ff;
   logic signed [VALUE_W-1:0] value_ff;
   logic [COUNT_W-1:0]        count_ff, count_in;
   logic [STATUS_W-1:0]       status_ff, status_in;
   logic                      rank_en_ff;
   logic                      strobe_ff;
   rsp_type                   rsp_ff;
   logic                      accept;
   logic                      hit;
   logic                      full;
   logic                      do_insert;
   logic                      do_delete;

   assign busy   = (state_ff != ST_IDLE);
   assign accept = start && !busy;
   assign hit    = |eq_flags;
   assign full   = (count_ff == COUNT_W'(CAPACITY));

   always_comb begin
      status_in = STATUS_OK;
      do_insert = 1'b0;
      do_delete = 1'b0;
      unique case (cmd_ff)
         CMD_INSERT: begin
            if (hit) begin
               status_in = STATUS_MISS;
            end else if (full) begin
               status_in = STATUS_FULL;
            end else begin
               do_insert = 1'b1;
            end
         end
         CMD_DELETE: begin
            if (hit) begin
               do_delete = 1'b1;
            end else begin
               status_in = STATUS_MISS;
            end
         end
         CMD_MEMBER: status_in = hit ? STATUS_OK : STATUS_MISS;
         default:    status_in = STATUS_OK;
      endcase
   end

   always_comb begin
      state_in = state_ff;
      count_in = count_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_APPLY;
            end
         end
         ST_APPLY: begin
            state_in = ST_SUM;
            if (do_insert) begin
               count_in = count_ff + COUNT_W'(1);
            end else if (do_delete) begin
               count_in = count_ff - COUNT_W'(1);
            end
         end
         ST_SUM:  state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   assign cell_ctl.capture   = accept;
   assign cell_ctl.insert    = (state_ff == ST_APPLY) && do_insert;
   assign cell_ctl.delete_op = (state_ff == ST_APPLY) && do_delete;
   assign cell_ctl.value     = accept ? req_payload.value : value_ff;

   // The flags still describe the set as it was before this transaction.
   assign count_bits = (cmd_ff == CMD_GREATER) ? gt_flags : lt_flags;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         count_ff  <= '0;
         strobe_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         count_ff  <= count_in;
         strobe_ff <= (state_ff == ST_SUM);
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         cmd_ff   <= req_payload.command;
         value_ff <= req_payload.value;
      end
      if (state_ff == ST_APPLY) begin
         status_ff  <= status_in;
         rank_en_ff <= (cmd_ff == CMD_GREATER) || (cmd_ff == CMD_LESS);
      end
      if (state_ff == ST_SUM) begin
         rsp_ff.status     <= status_ff;
         rsp_ff.rank_count <= rank_en_ff ? RANK_W'(count_total) : '0;
         rsp_ff.set_size   <= SIZE_W'(count_ff);
         rsp_ff.is_empty   <= (count_ff == '0);
      end
   end

   assign rsp_strobe  = strobe_ff;
   assign rsp_payload = rsp_ff;

endmodule

// ===== rtl/sorted_integer_set_top.sv =====
// Sorted integer set: a chain of compare-and-shift cells with a sequencer and popcount.
// Depends on sis_pkg, sis_cell, sis_popcnt and sis_ctl.
//
// Usage:
//   A request transaction (req_payload: command and signed value) is taken at a
//   rising edge where start is high and busy is low. Commands are insert,
//   delete, membership test, count greater and count less.
//   Each request produces exactly one response on rsp_payload, shown for one
//   cycle with rsp_strobe high; it is registered at the end of the SUM state,
//   which follows the APPLY state after the accepting edge.
//   busy stays high through the APPLY and SUM states after acceptance, so a
//   new request waits for the compare, the shift of the cell chain and the
//   registered popcount stage of the one before it.
//   A response may be on the ports while the next request is accepted.
//   The receiver cannot stall; a response is gone after its cycle.
//   Reset (synchronous, active high) empties the set and drops any
//   transaction in flight; stored element values are not cleared.
//   Capacity is sis_pkg::CAPACITY elements; inserting an absent value into a
//   full set reports status full and leaves the set unchanged.
module sorted_integer_set_top (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  sis_pkg::req_type req_payload,
   output logic             rsp_strobe,
   output sis_pkg::rsp_type rsp_payload
);
   import sis_pkg::*;

   cell_ctl_type              cell_ctl;
   logic signed [VALUE_W-1:0] cell_value [CAPACITY];
   logic                      cell_valid [CAPACITY];
   logic [CAPACITY-1:0]       lt_flags;
   logic [CAPACITY-1:0]       eq_flags;
   logic [CAPACITY-1:0]       gt_flags;
   logic [CAPACITY-1:0]       count_bits;
   logic [COUNT_W-1:0]        count_total;

   sis_ctl u_ctl (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .busy        (busy),
      .req_payload (req_payload),
      .rsp_strobe  (rsp_strobe),
      .rsp_payload (rsp_payload),
      .cell_ctl    (cell_ctl),
      .eq_flags    (eq_flags),
      .lt_flags    (lt_flags),
      .gt_flags    (gt_flags),
      .count_bits  (count_bits),
      .count_total (count_total)
   );

   sis_popcnt u_popcnt (
      .clock (clock),
      .bits  (count_bits),
      .total (count_total)
   );

   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      logic signed [VALUE_W-1:0] left_value;
      logic                      left_valid;
      logic                      left_lt;
      logic signed [VALUE_W-1:0] right_value;
      logic                      right_valid;

      // The bottom cell sees a virtual neighbor that is valid and below any value.
      if (i == 0) begin : g_left_edge
         assign left_value = '0;
         assign left_valid = 1'b1;
         assign left_lt    = 1'b1;
      end else begin : g_left
         assign left_value = cell_value[i-1];
         assign left_valid = cell_valid[i-1];
         assign left_lt    = lt_flags[i-1];
      end

      if (i == CAPACITY - 1) begin : g_right_edge
         assign right_value = '0;
         assign right_valid = 1'b0;
      end else begin : g_right
         assign right_value = cell_value[i+1];
         assign right_valid = cell_valid[i+1];
      end

      sis_cell u_cell (
         .clock       (clock),
         .reset       (reset),
         .ctl         (cell_ctl),
         .left_value  (left_value),
         .left_valid  (left_valid),
         .left_lt     (left_lt),
         .right_value (right_value),
         .right_valid (right_valid),
         .value       (cell_value[i]),
         .valid       (cell_valid[i]),
         .lt          (lt_flags[i]),
         .eq          (eq_flags[i]),
         .gt          (gt_flags[i])
      );
   end

`ifndef SYNTHESIS
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("busy not raised after an accepted request");

   a_latency: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##3 rsp_strobe)
      else $error("response missing three cycles after acceptance");

   a_strobe_origin: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(busy))
      else $error("response strobe without a request in flight");

   a_empty_flag: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> (rsp_payload.is_empty == (rsp_payload.set_size == '0)))
      else $error("is_empty disagrees with set_size");

   a_size_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> (rsp_payload.set_size <= SIZE_W'(CAPACITY)))
      else $error("set_size above capacity");
`endif

endmodule
